### src/ssat_pkg.sv
`default_nettype none

package ssat_pkg;

  localparam int SUM_W   = 40;
  localparam int VALUE_W = 32;
  localparam int SEG_W   = 8;
  localparam int FEAT_W  = 4;
  localparam int REQ_W   = 2;

  localparam int DEF_SEGMENTS = 256;
  localparam int DEF_FEATURES = 16;

  localparam logic [REQ_W-1:0] REQ_ACCUM      = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ       = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ_CLEAR = 2'd2;

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Control of the item held in the update stage.
  typedef struct packed {
    logic             valid;
    logic [REQ_W-1:0] req;
    logic             hit;
  } ssat_ctl_t;

endpackage

`default_nettype wire

### src/ssat_table.sv
`default_nettype none

module ssat_table #(
  parameter int DEPTH  = ssat_pkg::DEF_SEGMENTS * ssat_pkg::DEF_FEATURES,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [ADDR_W-1:0]          rd_addr,
  output logic      [ssat_pkg::SUM_W-1:0] rd_data,
  input  wire logic                       wr_en,
  input  wire logic [ADDR_W-1:0]          wr_addr,
  input  wire logic [ssat_pkg::SUM_W-1:0] wr_data,
  output logic                            clearing
);
  import ssat_pkg::*;

  logic [SUM_W-1:0]  mem [DEPTH];
  logic [ADDR_W-1:0] clr_addr;

  // After reset every entry is swept to zero, one entry per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  a_no_write_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !wr_en)
    else $error("table written during clearing pass");

  a_clear_ends: assert property (@(posedge clk) disable iff (rst)
    (clearing && clr_addr == ADDR_W'(DEPTH - 1)) |=> !clearing)
    else $error("clearing pass did not end at the last entry");

  a_clear_stays_done: assert property (@(posedge clk) disable iff (rst)
    !clearing |=> !clearing)
    else $error("clearing pass restarted without reset");

endmodule

`default_nettype wire

### src/ssat_update.sv
`default_nettype none

module ssat_update #(
  parameter int ADDR_W = 12
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire ssat_pkg::ssat_ctl_t          ctl,
  input  wire logic [ADDR_W-1:0]            addr,
  input  wire logic [ssat_pkg::VALUE_W-1:0] value,
  input  wire logic [ssat_pkg::SUM_W-1:0]   rd_data,
  output logic                              wr_en,
  output logic      [ADDR_W-1:0]            wr_addr,
  output logic      [ssat_pkg::SUM_W-1:0]   wr_data,
  output logic                              done,
  output logic      [ssat_pkg::SUM_W-1:0]   sum,
  output logic                              overflow
);
  import ssat_pkg::*;

  logic              overflow_seen;
  logic              overflow_seen_next;
  logic              fwd_valid;
  logic [ADDR_W-1:0] fwd_addr;
  logic [SUM_W-1:0]  fwd_data;
  logic [SUM_W-1:0]  operand;
  logic [SUM_W:0]    total;
  logic              sat;
  logic [SUM_W-1:0]  clamped;
  logic              res_now;

  // The memory returns the old word when the previous item wrote the same
  // entry at the edge of the read, so that write is forwarded here.
  assign operand = (fwd_valid && fwd_addr == addr) ? fwd_data : rd_data;

  assign total = {operand[SUM_W-1], operand}
               + {{(SUM_W + 1 - VALUE_W){value[VALUE_W-1]}}, value};
  assign sat     = total[SUM_W] != total[SUM_W-1];
  assign clamped = sat ? (total[SUM_W] ? SUM_MIN : SUM_MAX) : total[SUM_W-1:0];

  always_comb begin
    wr_en              = 1'b0;
    wr_data            = clamped;
    res_now            = 1'b0;
    overflow_seen_next = overflow_seen;
    if (ctl.valid) begin
      unique case (ctl.req)
        REQ_ACCUM: begin
          wr_en = ctl.hit;
          if (ctl.hit && sat) begin
            overflow_seen_next = 1'b1;
          end
        end
        REQ_READ: begin
          res_now = 1'b1;
        end
        REQ_READ_CLEAR: begin
          res_now            = 1'b1;
          wr_en              = ctl.hit;
          wr_data            = '0;
          overflow_seen_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign wr_addr = addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_seen <= 1'b0;
      fwd_valid     <= 1'b0;
      done          <= 1'b0;
    end else begin
      overflow_seen <= overflow_seen_next;
      fwd_valid     <= wr_en;
      done          <= res_now;
    end
    fwd_addr <= wr_addr;
    fwd_data <= wr_data;
    sum      <= ctl.hit ? operand : '0;
    overflow <= overflow_seen;
  end

  a_done_from_read: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(ctl.valid && (ctl.req == REQ_READ || ctl.req == REQ_READ_CLEAR)))
    else $error("result strobe without a read item");

  a_clear_drops_flag: assert property (@(posedge clk) disable iff (rst)
    (ctl.valid && ctl.req == REQ_READ_CLEAR) |=> !overflow_seen)
    else $error("overflow flag survived a read-and-clear");

  a_miss_no_write: assert property (@(posedge clk) disable iff (rst)
    (ctl.valid && !ctl.hit) |-> !wr_en)
    else $error("out-of-range item wrote the table");

endmodule

`default_nettype wire

### src/segment_scatter_add_table_unit.sv
`default_nettype none

// Scatter-add table: accumulates signed Q16.16 values into a table of
// SEGMENTS x FEATURES saturating 40-bit Q24.16 entries.
// An item is transferred at a rising edge with start high and busy low. It
// carries req_type (accumulate, read, read-and-clear), segment, feature and,
// for accumulate, value. Accumulate produces no result; read and
// read-and-clear produce one result on sum and overflow, marked by done for
// exactly one cycle, via the update-stage register and the done register.
// An item may be transferred on every cycle while busy is low: each item
// passes the read-modify-write stage, with the table's registered read
// covered by forwarding the previous write when both address the same entry.
// The result receiver cannot stall; it must take each result while done is
// high.
// After reset, busy stays high while the table is swept to zero one entry
// per cycle, SEGMENTS x FEATURES entries (4096 at the default size); the
// overflow flag is cleared at once. busy is low at all other times.
// Entries addressed outside the table are ignored by accumulate and read as
// zero; read-and-clear then clears only the overflow flag.
module segment_scatter_add_table_unit #(
  parameter int SEGMENTS = ssat_pkg::DEF_SEGMENTS,
  parameter int FEATURES = ssat_pkg::DEF_FEATURES
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [ssat_pkg::REQ_W-1:0]   req_type,
  input  wire logic [ssat_pkg::SEG_W-1:0]   segment,
  input  wire logic [ssat_pkg::FEAT_W-1:0]  feature,
  input  wire logic [ssat_pkg::VALUE_W-1:0] value,
  output logic                              done,
  output logic      [ssat_pkg::SUM_W-1:0]   sum,
  output logic                              overflow
);
  import ssat_pkg::*;

  localparam int DEPTH  = SEGMENTS * FEATURES;
  localparam int ADDR_W = $clog2(DEPTH);

  logic              accept;
  logic              in_range;
  logic [ADDR_W-1:0] in_addr;
  ssat_ctl_t         stage;
  logic [ADDR_W-1:0] stage_addr;
  logic [VALUE_W-1:0] stage_value;
  logic [SUM_W-1:0]  rd_data;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [SUM_W-1:0]  wr_data;
  logic              clearing;

  assign accept   = start && !busy;
  assign in_range = (32'(segment) < 32'(SEGMENTS)) && (32'(feature) < 32'(FEATURES));
  assign in_addr  = in_range ? ADDR_W'(32'(segment) * 32'(FEATURES) + 32'(feature)) : '0;
  assign busy     = clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else begin
      stage.valid <= accept;
    end
    stage.req   <= req_type;
    stage.hit   <= in_range;
    stage_addr  <= in_addr;
    stage_value <= value;
  end

  ssat_table #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (in_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .clearing (clearing)
  );

  ssat_update #(
    .ADDR_W (ADDR_W)
  ) u_update (
    .clk      (clk),
    .rst      (rst),
    .ctl      (stage),
    .addr     (stage_addr),
    .value    (stage_value),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .done     (done),
    .sum      (sum),
    .overflow (overflow)
  );

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done)
    else $error("result strobe during clearing pass");

  a_stage_follows_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> stage.valid)
    else $error("transferred item did not enter the update stage");

  a_no_stage_in_clear: assert property (@(posedge clk) disable iff (rst)
    busy |=> !stage.valid)
    else $error("item entered the update stage during clearing pass");

endmodule

`default_nettype wire
